@@ design/mcs_pkg.sv @@
// Shared types and constants for the min/max contrast stretch block.
// No dependencies; imported by every module in design/.
`default_nettype none

package mcs_pkg;

    // Default gray sample width
    localparam int PIXEL_BITS_DEF = 8;

    // Request type codes
    localparam logic REQ_MEASURE = 1'b0;
    localparam logic REQ_APPLY   = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_meas;   // update running min/max with the input pixel
        logic load_apply;  // latch operands for a new stretch
        logic step;        // one restoring-divide iteration
        logic load_out;    // move the finished quotient to the output register
    } t_dp_cmd;

endpackage

`default_nettype wire

@@ design/minmax_contrast_stretch_8bit.sv @@
// Min/max contrast stretch, top level.
// Channels: input (i_in_valid / o_in_stall) carries req_type, pixel and
// first_of_frame; output (o_out_valid / i_out_stall) carries stretched.
// A transaction moves when valid is high and stall is low at a clock edge.
// Measure transactions (req_type 0) give no result;
// first_of_frame restarts the running min and max at that pixel.
// Apply transactions (req_type 1) give floor((p-min)*2^N/(max-min)),
// saturated to 2^N-1, or 0 when p < min or max <= min.
// Apply sequence: the restoring divider forms the PIXEL_BITS quotient
// bits, one per step, then the output register is loaded and o_out_valid
// rises; the input is released in the same cycle that o_out_valid rises.
// The input stays stalled while a divide is in progress.
// A held result does not block new input; a finished divide waits in
// place while the output register is full and stalled.
// Reset (synchronous, active low) empties the pipeline and sets min to
// all ones and max to zero, so applies before any measure give 0.
`default_nettype none

module minmax_contrast_stretch_8bit #(
    parameter int PIXEL_BITS = mcs_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_req_type,
    input  wire logic [PIXEL_BITS-1:0] i_pixel,
    input  wire logic                  i_first_of_frame,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [PIXEL_BITS-1:0]      o_stretched
);
    import mcs_pkg::*;

    t_dp_cmd cmd;

    // Sequencer
    mcs_ctrl #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // Arithmetic
    mcs_dp #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_pixel          (i_pixel),
        .i_first_of_frame (i_first_of_frame),
        .o_stretched      (o_stretched)
    );

endmodule

`default_nettype wire

@@ design/mcs_ctrl.sv @@
// Controller FSM for the contrast stretch: handshakes and divide sequencing.
// Depends on mcs_pkg; drives the command struct of mcs_dp.
`default_nettype none

module mcs_ctrl #(
    parameter int PIXEL_BITS = mcs_pkg::PIXEL_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire logic            i_req_type,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output mcs_pkg::t_dp_cmd     o_cmd
);
    import mcs_pkg::*;

    localparam int CNT_W = (PIXEL_BITS > 1) ? $clog2(PIXEL_BITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PIXEL_BITS - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    // Output register can take a new transaction this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && (i_req_type == REQ_APPLY))
                    n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == CNT_LAST)
                    n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs / commands
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall       = 1'b0;
                o_cmd.load_meas  = i_in_valid && (i_req_type == REQ_MEASURE);
                o_cmd.load_apply = i_in_valid && (i_req_type == REQ_APPLY);
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
            end
            S_DONE: begin
                o_cmd.load_out = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Iteration counter and output valid
    always_comb begin
        n_cnt = (r_state == S_DIV) ? r_cnt + 1'b1 : '0;
        if (o_cmd.load_out)
            n_out_valid = 1'b1;
        else if (!i_out_stall)
            n_out_valid = 1'b0;
        else
            n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ design/mcs_dp.sv @@
// Datapath for the contrast stretch: min/max tracking, restoring divider,
// output register. Depends on mcs_pkg; driven by mcs_ctrl commands.
`default_nettype none

module mcs_dp #(
    parameter int PIXEL_BITS = mcs_pkg::PIXEL_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mcs_pkg::t_dp_cmd      i_cmd,
    input  wire logic [PIXEL_BITS-1:0] i_pixel,
    input  wire logic                  i_first_of_frame,
    output logic [PIXEL_BITS-1:0]      o_stretched
);
    import mcs_pkg::*;

    localparam int N = PIXEL_BITS;

    logic [N-1:0] r_min, r_max;
    logic [N-1:0] r_rem, r_den, r_quot, r_out;
    logic         r_zero, r_full;

    logic         range_empty, below_min, at_or_above;
    logic [N-1:0] diff, den;
    logic [N:0]   trial;
    logic         fits;

    // Operand prep for a new stretch
    assign range_empty = (r_max <= r_min);
    assign below_min   = (i_pixel < r_min);
    assign diff        = i_pixel - r_min;
    assign den         = r_max - r_min;
    // quotient reaches 2^N exactly when diff >= den: saturate
    assign at_or_above = (diff >= den);

    // One restoring-divide step; remainder stays below den
    assign trial = {r_rem, 1'b0};
    assign fits  = (trial >= {1'b0, r_den});

    // Running min/max (state with defined reset)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '1;
            r_max <= '0;
        end else if (i_cmd.load_meas) begin
            if (i_first_of_frame) begin
                r_min <= i_pixel;
                r_max <= i_pixel;
            end else begin
                if (i_pixel < r_min)
                    r_min <= i_pixel;
                if (i_pixel > r_max)
                    r_max <= i_pixel;
            end
        end
    end

    // Divider and output payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_apply) begin
            r_rem  <= diff;
            r_den  <= den;
            r_quot <= '0;
            r_zero <= range_empty || below_min;
            r_full <= !range_empty && !below_min && at_or_above;
        end else if (i_cmd.step) begin
            r_rem  <= fits ? N'(trial - {1'b0, r_den}) : trial[N-1:0];
            r_quot <= {r_quot[N-2:0], fits};
        end
        if (i_cmd.load_out)
            r_out <= r_zero ? '0 : (r_full ? '1 : r_quot);
    end

    assign o_stretched = r_out;

endmodule

`default_nettype wire
